FILE: hw/rtl/touch_pad_detector_defines.svh
// assertion helpers for the touch pad detector top module
`ifndef TOUCH_PAD_DETECTOR_DEFINES_SVH
`define TOUCH_PAD_DETECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tpd_pkg.sv
package tpd_pkg;

	localparam int SAMPLE_W = 16;

	// scan lengths and hold-off reload
	localparam logic [2:0] SCAN_SHORT  = 3'd3;
	localparam logic [2:0] SCAN_LONG   = 3'd6;
	localparam logic [1:0] HOLDOFF_SET = 2'd3;

	// configuration register indexes
	localparam logic REG_GATE   = 1'b0;
	localparam logic REG_REPEAT = 1'b1;

	localparam logic [SAMPLE_W-1:0] GATE_RESET = 16'd100;

	// what one cell shows its neighbors
	typedef struct packed {
		logic [SAMPLE_W-1:0] val;
		logic                valid;
		logic                gt;
	} tpd_link_t;

	// chain control
	typedef struct packed {
		logic insert;
		logic drain;
	} tpd_ctl_t;

	// averaging unit status
	typedef struct packed {
		logic drain;
		logic done;
	} tpd_avg_st_t;

endpackage

FILE: hw/rtl/touch_pad_detector.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   sample[15:0]
// out       output     out_valid / out_stall pressed, peak[15:0], baseline[15:0]
// cfg       input      cfg_we (no wait)      cfg_index[0], cfg_data[15:0]
//
// calibration samples are taken one a cycle, each insertion into the sorted cell chain
// after the last calibration item the chain drains into the averaging unit, which
//   accumulates the middle of the drained values, multiplies by the reciprocal and then
//   loads the baseline, with in_stall held high
// afterward one item per cycle while in_stall is low; a scan result shows on the out port
//   the cycle after the item that closes the scan
// in the run phase in_stall rises only when the next item would close a scan while an older result is stalled
// arst_n clears all control state; the chain contents need no reset
module touch_pad_detector #(
	parameter int CAL_SAMPLES    = 10,
	parameter int TRIM_EACH_SIDE = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tpd_pkg::SAMPLE_W-1:0]  sample,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          pressed,
	output logic [tpd_pkg::SAMPLE_W-1:0]  peak,
	output logic [tpd_pkg::SAMPLE_W-1:0]  baseline,
	// register writes
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [tpd_pkg::SAMPLE_W-1:0]  cfg_data
);
	import tpd_pkg::*;
	`include "touch_pad_detector_defines.svh"

	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);

	typedef enum logic [2:0] {
		PH_CAL = 3'b001,
		PH_AVG = 3'b010,
		PH_RUN = 3'b100
	} phase_t;

	// configuration registers
	logic [SAMPLE_W-1:0] gate_q;
	logic                repeat_q;

	// control state
	phase_t              phase_q;
	logic [CNT_W-1:0]    cal_count_q;
	logic [2:0]          scan_count_q;
	logic [1:0]          holdoff_q;
	logic                out_valid_q;

	// data state
	logic [SAMPLE_W-1:0] baseline_q;
	logic [SAMPLE_W-1:0] run_peak_q;
	logic                pressed_q;
	logic [SAMPLE_W-1:0] peak_out_q;

	// chain wiring
	tpd_link_t           link [CAL_SAMPLES];
	tpd_link_t           seed;
	tpd_ctl_t            ctl;
	tpd_avg_st_t         avg_st;
	logic [SAMPLE_W-1:0] avg_val;

	// scan datapath
	logic                in_acc;
	logic [2:0]          scan_len;
	logic [2:0]          cnt_next;
	logic                emit_c;
	logic [1:0]          ho_start;
	logic [1:0]          ho_after;
	logic [SAMPLE_W-1:0] new_peak;
	logic [SAMPLE_W:0]   limit;
	logic                detect;

	// register writes, to be issued only while the block is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q   <= GATE_RESET;
			repeat_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GATE:   gate_q   <= cfg_data;
				REG_REPEAT: repeat_q <= cfg_data[0];
				default:    gate_q   <= gate_q;
			endcase
		end
	end

	// the scan closes when its count reaches or passes the length chosen by the current mode
	assign scan_len = repeat_q ? SCAN_LONG : SCAN_SHORT;
	assign cnt_next = scan_count_q + 3'd1;
	assign emit_c   = (phase_q == PH_RUN) && (cnt_next >= scan_len);

	// hold back only the phases or items that cannot be absorbed now
	assign in_stall = (phase_q == PH_AVG) || (emit_c && out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	// repeat mode opens every scan with a clear hold-off
	assign ho_start = (scan_count_q == 3'd0 && repeat_q) ? 2'd0 : holdoff_q;
	assign new_peak = (sample > run_peak_q) ? sample : run_peak_q;

	// full-width compare so baseline plus gate cannot wrap
	assign limit  = {1'b0, baseline_q} + {1'b0, gate_q};
	assign detect = ({1'b0, new_peak} > limit);

	// a detection reloads the hold-off, then every closed scan counts it down
	always_comb begin
		if (detect) begin
			ho_after = HOLDOFF_SET - 2'd1;
		end else if (ho_start != 2'd0) begin
			ho_after = ho_start - 2'd1;
		end else begin
			ho_after = 2'd0;
		end
	end

	// sorted insertion chain, smallest value in cell 0
	assign seed = '{val: sample, valid: 1'b1, gt: 1'b0};
	assign ctl  = '{insert: in_acc && (phase_q == PH_CAL), drain: avg_st.drain};

	for (genvar i = 0; i < CAL_SAMPLES; i++) begin : g_cell
		tpd_link_t           prev_l;
		logic [SAMPLE_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_l = seed;
		end else begin : g_mid
			assign prev_l = link[i-1];
		end

		if (i == CAL_SAMPLES - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_inner
			assign next_v = link[i+1].val;
		end

		tpd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sample   (sample),
			.prev     (prev_l),
			.next_val (next_v),
			.link     (link[i])
		);
	end

	// trimmed mean of the drained chain
	tpd_avg #(
		.CAL_SAMPLES    (CAL_SAMPLES),
		.TRIM_EACH_SIDE (TRIM_EACH_SIDE)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.insert && (cal_count_q == CAL_LAST)),
		.head   (link[0].val),
		.st     (avg_st),
		.avg    (avg_val)
	);

	// phase sequencing and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CAL;
			cal_count_q  <= '0;
			scan_count_q <= 3'd0;
			holdoff_q    <= 2'd0;
			run_peak_q   <= '0;
			baseline_q   <= '0;
		end else begin
			unique case (phase_q)
				PH_CAL: begin
					if (in_acc) begin
						cal_count_q <= cal_count_q + 1'b1;
						if (cal_count_q == CAL_LAST) begin
							phase_q <= PH_AVG;
						end
					end
				end
				PH_AVG: begin
					if (avg_st.done) begin
						phase_q    <= PH_RUN;
						baseline_q <= avg_val;
					end
				end
				PH_RUN: begin
					if (in_acc) begin
						if (emit_c) begin
							holdoff_q    <= ho_after;
							scan_count_q <= 3'd0;
							run_peak_q   <= '0;
						end else begin
							holdoff_q    <= ho_start;
							scan_count_q <= cnt_next;
							run_peak_q   <= new_peak;
						end
					end
				end
				default: begin
					phase_q <= PH_CAL;
				end
			endcase
		end
	end

	// result valid: set by a closing item, cleared once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && emit_c) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (in_acc && emit_c) begin
			pressed_q  <= detect && (ho_start == 2'd0);
			peak_out_q <= new_peak;
		end
	end

	assign out_valid = out_valid_q;
	assign pressed   = pressed_q;
	assign peak      = peak_out_q;
	assign baseline  = baseline_q;

	`TPD_ASSERT_IMPL(a_no_result_in_cal, phase_q != PH_RUN, !out_valid_q, "result before calibration done")
	`TPD_ASSERT_IMPL(a_scan_bound, in_valid || !in_valid, scan_count_q < SCAN_LONG, "scan count out of range")
	`TPD_ASSERT_IMPL(a_holdoff_bound, in_valid || !in_valid, holdoff_q != HOLDOFF_SET, "hold-off left at reload value")
	`TPD_ASSERT_NEXT(a_emit_shows, in_acc && emit_c, out_valid_q, "closed scan gave no result")
	`TPD_ASSERT_NEXT(a_avg_to_run, avg_st.done, phase_q == PH_RUN, "baseline done but not running")

endmodule

FILE: hw/rtl/tpd_cell.sv
module tpd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpd_pkg::tpd_ctl_t             ctl,
	input  logic [tpd_pkg::SAMPLE_W-1:0]  sample,
	input  tpd_pkg::tpd_link_t            prev,
	input  logic [tpd_pkg::SAMPLE_W-1:0]  next_val,
	output tpd_pkg::tpd_link_t            link
);
	import tpd_pkg::*;

	logic [SAMPLE_W-1:0] val_q;
	logic                valid_q;
	logic                gt;

	// empty cells count as larger than anything
	assign gt = !valid_q || (val_q > sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev.gt) begin
				val_q <= prev.val;
			end else if (gt) begin
				val_q <= sample;
			end
		end else if (ctl.drain) begin
			val_q <= next_val;
		end
	end

	assign link = '{val: val_q, valid: valid_q, gt: gt};

endmodule

FILE: hw/rtl/tpd_avg.sv
module tpd_avg #(
	parameter int CAL_SAMPLES    = 10,
	parameter int TRIM_EACH_SIDE = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tpd_pkg::SAMPLE_W-1:0]  head,
	output tpd_pkg::tpd_avg_st_t          st,
	output logic [tpd_pkg::SAMPLE_W-1:0]  avg
);
	import tpd_pkg::*;

	localparam int TRIM_EFF = (2 * TRIM_EACH_SIDE >= CAL_SAMPLES) ?
		(CAL_SAMPLES - 1) / 2 : TRIM_EACH_SIDE;
	localparam int CNT     = CAL_SAMPLES - 2 * TRIM_EFF;
	localparam int SUM_W   = SAMPLE_W + $clog2(CAL_SAMPLES);
	localparam int IDX_W   = $clog2(CAL_SAMPLES);
	localparam int SHIFT   = SUM_W + $clog2(CNT);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	// rounded-up reciprocal of the count, exact for any sum below 2**SUM_W
	localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(CNT) - 1) /
		longint'(CNT);

	localparam logic [IDX_W-1:0]   IDX_LO   = IDX_W'(TRIM_EFF);
	localparam logic [IDX_W-1:0]   IDX_HI   = IDX_W'(CAL_SAMPLES - 1 - TRIM_EFF);
	localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(CAL_SAMPLES - 1);
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);

	typedef enum logic [2:0] {
		A_IDLE  = 3'b001,
		A_DRAIN = 3'b010,
		A_DIV   = 3'b100
	} avg_state_t;

	avg_state_t        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  num_q;
	logic              done_q;
	logic              in_window;
	logic [SUM_W-1:0]  acc_next;
	logic [PROD_W-1:0] prod;

	assign in_window = (idx_q >= IDX_LO) && (idx_q <= IDX_HI);
	assign acc_next  = num_q + (in_window ? SUM_W'(head) : '0);

	// divide by the constant count as a multiply by its reciprocal
	assign prod = PROD_W'(num_q) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						state_q <= A_DRAIN;
						idx_q   <= '0;
					end
				end
				A_DRAIN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						state_q <= A_DIV;
					end
				end
				A_DIV: begin
					state_q <= A_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && start) begin
			num_q <= '0;
		end else if (state_q == A_DRAIN) begin
			num_q <= acc_next;
		end else if (state_q == A_DIV) begin
			num_q <= SUM_W'(prod >> SHIFT);
		end
	end

	assign st  = '{drain: (state_q == A_DRAIN), done: done_q};
	assign avg = num_q[SAMPLE_W-1:0];

endmodule

FILE: dv/tb_touch_pad_detector.sv
module tb_touch_pad_detector;
	timeunit 1ns;
	timeprecision 1ps;

	// block geometry, kept apart from the rtl
	localparam int CAL_N       = 10;
	localparam int CAL_TRIM    = 2;
	localparam logic [2:0] SHORT_SCAN  = 3'd3;
	localparam logic [2:0] LONG_SCAN   = 3'd6;
	localparam logic [1:0] HOLD_RELOAD = 2'd3;

	// run shape
	localparam int IDLE_PCT     = 32;
	localparam int RANDOM_ITEMS = 2000;
	// covers the calibration drain with margin
	localparam int DRAIN_WAIT   = 64;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic        pressed;
		logic [15:0] peak;
		logic [15:0] baseline;
	} scan_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [tpd_pkg::SAMPLE_W-1:0] sample = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic                         pressed;
	logic [tpd_pkg::SAMPLE_W-1:0] peak;
	logic [tpd_pkg::SAMPLE_W-1:0] baseline;
	logic                         cfg_we = 1'b0;
	logic                         cfg_index = tpd_pkg::REG_GATE;
	logic [tpd_pkg::SAMPLE_W-1:0] cfg_data = '0;

	touch_pad_detector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pressed   (pressed),
		.peak      (peak),
		.baseline  (baseline),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// detector shadow state
	logic [15:0] cal_samples [CAL_N];
	int          cal_fill = 0;
	logic [15:0] base_now = '0;
	logic [2:0]  scan_fill = '0;
	logic [15:0] peak_now = '0;
	logic [1:0]  holdoff_now = '0;
	// register shadows, at their reset values
	logic [15:0] gate_now = 16'd100;
	logic        repeat_now = 1'b0;

	logic [15:0]  sample_queue [$];
	scan_report_t expected_scans [$];
	scan_report_t oldest;
	int           pushed_total = 0;
	int           taken_total = 0;
	int           mismatches = 0;
	int           idle_pct = IDLE_PCT;
	int unsigned  cycles = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// advance the shadow detector by one accepted item
	task automatic take_sample(input logic [15:0] s);
		logic [15:0]  ordered [CAL_N];
		logic [15:0]  v;
		int           i, j, trim;
		logic [31:0]  sum;
		logic [2:0]   len;
		scan_report_t rep;
		if (cal_fill < CAL_N) begin
			cal_samples[cal_fill] = s;
			cal_fill++;
			if (cal_fill == CAL_N) begin
				// sort, drop the ends, truncated mean of the middle
				ordered = cal_samples;
				for (i = 1; i < CAL_N; i++) begin
					v = ordered[i];
					j = i;
					while (j > 0 && ordered[j-1] > v) begin
						ordered[j] = ordered[j-1];
						j--;
					end
					ordered[j] = v;
				end
				trim = (2 * CAL_TRIM >= CAL_N) ? (CAL_N - 1) / 2 : CAL_TRIM;
				sum = '0;
				for (i = trim; i < CAL_N - trim; i++)
					sum += ordered[i];
				base_now = 16'(sum / (CAL_N - 2 * trim));
			end
		end else begin
			// repeat mode forgets the hold-off at the start of each scan
			if (scan_fill == 3'd0 && repeat_now)
				holdoff_now = '0;
			if (s > peak_now)
				peak_now = s;
			scan_fill++;
			// length follows the mode as it stands at this item
			len = repeat_now ? LONG_SCAN : SHORT_SCAN;
			if (scan_fill >= len) begin
				rep.pressed = 1'b0;
				// 17-bit compare so baseline plus gate cannot wrap
				if (17'(peak_now) > 17'(base_now) + 17'(gate_now)) begin
					rep.pressed = (holdoff_now == 2'd0);
					holdoff_now = HOLD_RELOAD;
				end
				if (holdoff_now != 2'd0)
					holdoff_now--;
				rep.peak = peak_now;
				rep.baseline = base_now;
				expected_scans.push_back(rep);
				scan_fill = '0;
				peak_now = '0;
			end
		end
	endtask

	task automatic queue_sample(input logic [15:0] s);
		sample_queue.push_back(s);
		pushed_total++;
	endtask

	// register write, only issued while the detector is quiet
	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tpd_pkg::REG_GATE)
			gate_now = val;
		else
			repeat_now = val[0];
	endtask

	// every queued item taken, every scan result seen, then let the block drain
	task automatic settle();
		while (taken_total != pushed_total || expected_scans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// sample driver: payload holds while stalled, gaps only between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				take_sample(sample);
				taken_total++;
			end
			if (!in_valid || !in_stall) begin
				if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					in_valid <= 1'b1;
					sample   <= sample_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_scans.size() == 0) begin
					report_mismatch("scan result with none pending");
				end else begin
					oldest = expected_scans.pop_front();
					if (pressed !== oldest.pressed)
						report_mismatch($sformatf("pressed %b, want %b", pressed,
							oldest.pressed));
					if (peak !== oldest.peak)
						report_mismatch($sformatf("peak %0d, want %0d", peak, oldest.peak));
					if (baseline !== oldest.baseline)
						report_mismatch($sformatf("baseline %0d, want %0d", baseline,
							oldest.baseline));
				end
			end
			out_stall <= ($urandom_range(0, 99) < idle_pct);
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_touch_pad_detector: FAIL");
			$finish;
		end
	end

	initial begin
		int          cal_center, ph, n, k, r, randoms_sent;
		logic [15:0] g;
		logic [16:0] t;
		int          b;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// calibration: both rails plus a cluster, rails land in the trimmed ends
		cal_center = $urandom_range(0, 60000);
		for (k = 0; k < CAL_N; k++) begin
			if (k == 0)
				queue_sample(16'hFFFF);
			else if (k == 5)
				queue_sample(16'h0000);
			else
				queue_sample(16'($urandom_range(cal_center, cal_center + 3000)));
		end
		settle();
		b = base_now;

		// gate at reset value, three-item scans
		// peak exactly at baseline plus gate: no touch
		queue_sample(16'(b));
		queue_sample(16'(b + 100));
		queue_sample(16'(b));
		// one over: press, hold-off armed
		queue_sample(16'(b + 101));
		queue_sample(16'h0000);
		queue_sample(16'h0000);
		// top of range while held off: touch but no new press
		queue_sample(16'hFFFF);
		queue_sample(16'h0000);
		queue_sample(16'h0000);
		settle();

		// repeat mode with zero gate: hold-off cleared at scan start, so it presses again
		write_reg(tpd_pkg::REG_GATE, 16'h0000);
		write_reg(tpd_pkg::REG_REPEAT, 16'h0001);
		queue_sample(16'(b + 1));
		for (k = 0; k < 5; k++)
			queue_sample(16'(b));
		settle();

		// random phases; phase boundaries can fall mid-scan, so mode flips can land inside scans
		randoms_sent = 0;
		for (ph = 0; randoms_sent < RANDOM_ITEMS; ph++) begin
			case ($urandom_range(0, 4))
				0: g = 16'h0000;
				1: g = 16'hFFFF;
				2: g = 16'($urandom_range(0, 300));
				default: g = 16'($urandom);
			endcase
			write_reg(tpd_pkg::REG_GATE, g);
			// upper data bits are don't-care for the mode register
			write_reg(tpd_pkg::REG_REPEAT, {15'($urandom), 1'($urandom)});
			// one long stretch with no gaps on either side
			idle_pct = (ph == 2) ? 0 : IDLE_PCT;
			n = (ph == 2) ? 300 : $urandom_range(20, 150);
			for (k = 0; k < n; k++) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					t = 17'(base_now) + 17'($urandom_range(0, gate_now));
				else if (r < 80)
					t = 17'(base_now) + 17'(gate_now) + 17'($urandom_range(1, 200));
				else if (r < 90)
					t = 17'(base_now) + 17'(gate_now) + 17'($urandom_range(0, 1));
				else
					t = 17'($urandom_range(0, 65535));
				queue_sample(t > 17'h0FFFF ? 16'hFFFF : t[15:0]);
			end
			randoms_sent += n;
			settle();
		end

		if (mismatches == 0)
			$display("tb_touch_pad_detector: PASS");
		else
			$display("tb_touch_pad_detector: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_cell.sv
hw/rtl/tpd_avg.sv
hw/rtl/touch_pad_detector.sv
dv/tb_touch_pad_detector.sv
